### src/bprg_pkg.sv
// ----------------------------------------------------------------------------
// Baseline phasor row generator package
// Shared payload types, the queue entry and the Q1.15 complex arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package bprg_pkg;

  localparam int MAX_CHANNELS_DEFAULT = 64;
  localparam int CountW = 7;
  localparam int ChanW = 6;

  typedef logic signed [15:0] q15_t;

  typedef struct packed {
    q15_t a_start_re;
    q15_t a_start_im;
    q15_t b_start_re;
    q15_t b_start_im;
    q15_t a_step_re;
    q15_t a_step_im;
    q15_t b_step_re;
    q15_t b_step_im;
  } item_t;

  typedef struct packed {
    q15_t shift_re;
    q15_t shift_im;
    logic [ChanW-1:0] channel;
    logic last;
  } result_t;

  typedef struct packed {
    q15_t re;
    q15_t im;
  } cpx_t;

  typedef struct packed {
    cpx_t start;
    cpx_t step;
    logic [ChanW-1:0] last_idx;
  } job_t;

  function automatic q15_t rnd_sat(input logic signed [32:0] v);
    logic signed [33:0] biased;
    logic signed [18:0] r;
    biased = $signed({v[32], v}) + 34'sd16384;
    r = 19'(biased >>> 15);
    if (r > 19'sd32767) begin
      return 16'sh7fff;
    end else if (r < -19'sd32768) begin
      return 16'sh8000;
    end
    return r[15:0];
  endfunction

  function automatic logic signed [32:0] sext_prod(input logic signed [31:0] p);
    return $signed({p[31], p});
  endfunction

  // x * y
  function automatic cpx_t cmul(input cpx_t x, input cpx_t y);
    logic signed [31:0] rr, ii, ri, ir;
    cpx_t z;
    rr = x.re * y.re;
    ii = x.im * y.im;
    ri = x.re * y.im;
    ir = x.im * y.re;
    z.re = rnd_sat(sext_prod(rr) - sext_prod(ii));
    z.im = rnd_sat(sext_prod(ri) + sext_prod(ir));
    return z;
  endfunction

  // x * conj(y)
  function automatic cpx_t cmul_conj(input cpx_t x, input cpx_t y);
    logic signed [31:0] rr, ii, ri, ir;
    cpx_t z;
    rr = x.re * y.re;
    ii = x.im * y.im;
    ri = x.re * y.im;
    ir = x.im * y.re;
    z.re = rnd_sat(sext_prod(rr) + sext_prod(ii));
    z.im = rnd_sat(sext_prod(ir) - sext_prod(ri));
    return z;
  endfunction

endpackage

`default_nettype wire

### src/baseline_phasor_row_generator.sv
// ----------------------------------------------------------------------------
// Baseline phasor row generator
// Forms B * conj(A) and dB * conj(dA) per timeslot and emits one rotated
// phasor per frequency channel, all in rounded and saturated Q1.15.
// ----------------------------------------------------------------------------
//   Channel   Handshake          Payload
//   input     push / full        item   (bprg_pkg::item_t)
//   result    pop / empty        result (bprg_pkg::result_t)
//   config    wr_en              wr_data (channel_count, 7 bits)
//
// The front end holds full after each transaction while it forms the start
// and step and until the queue takes the job, so it takes a new timeslot
// only once the last one is queued. The recurrence engine emits one channel
// per cycle while results are popped and takes the next job from the queue
// only after the last channel of a row.
// Reset clears all control state and sets channel_count to 1.
// A low pop holds the current result and the recurrence waits with it.
// ----------------------------------------------------------------------------
`default_nettype none

module baseline_phasor_row_generator #(
  parameter int MAX_CHANNELS = bprg_pkg::MAX_CHANNELS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire bprg_pkg::item_t               item,
  output logic                               empty,
  input  wire logic                          pop,
  output bprg_pkg::result_t                  result,
  input  wire logic                          wr_en,
  input  wire logic [bprg_pkg::CountW-1:0]   wr_data
);
  import bprg_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  job_t q_in;
  job_t q_out;

  bprg_front #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .wr_en(wr_en),
    .wr_data(wr_data),
    .q_push(q_push),
    .q_full(q_full),
    .q_data(q_in)
  );

  bprg_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .full(q_full),
    .din(q_in),
    .pop(q_pop),
    .empty(q_empty),
    .dout(q_out)
  );

  bprg_back u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .q_pop(q_pop),
    .q_data(q_out),
    .empty(empty),
    .pop(pop),
    .result(result)
  );

endmodule

`default_nettype wire

### src/bprg_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts a timeslot, classifies the row length and forms the start value
// and the channel step before handing the job to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bprg_front #(
  parameter int MAX_CHANNELS = bprg_pkg::MAX_CHANNELS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire bprg_pkg::item_t               item,
  input  wire logic                          wr_en,
  input  wire logic [bprg_pkg::CountW-1:0]   wr_data,
  output logic                               q_push,
  input  wire logic                          q_full,
  output bprg_pkg::job_t                     q_data
);
  import bprg_pkg::*;

  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_CHANNELS);

  typedef enum logic [1:0] {F_IDLE, F_START, F_STEP} front_state_t;

  front_state_t state;
  logic [CountW-1:0] channel_count;
  logic [CountW-1:0] count_eff;
  item_t held;
  cpx_t start;
  logic [ChanW-1:0] last_idx;
  cpx_t step_val;

  always_comb begin
    count_eff = channel_count;
    if (count_eff == '0) begin
      count_eff = CountW'(1);
    end else if (count_eff > MaxCount) begin
      count_eff = MaxCount;
    end
  end

  always_comb begin
    if (last_idx == '0) begin
      step_val = '0;
    end else begin
      step_val = cmul_conj({held.b_step_re, held.b_step_im},
                           {held.a_step_re, held.a_step_im});
    end
  end

  assign full = (state != F_IDLE);
  assign q_push = (state == F_STEP) && !q_full;
  assign q_data = '{start: start, step: step_val, last_idx: last_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      channel_count <= CountW'(1);
    end else begin
      if (wr_en) begin
        channel_count <= wr_data;
      end
      case (state)
        F_IDLE: begin
          if (push) begin
            held <= item;
            last_idx <= ChanW'(count_eff - CountW'(1));
            state <= F_START;
          end
        end
        F_START: begin
          start <= cmul_conj({held.b_start_re, held.b_start_im},
                             {held.a_start_re, held.a_start_im});
          state <= F_STEP;
        end
        F_STEP: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### src/bprg_queue.sv
// ----------------------------------------------------------------------------
// Job queue
// A two-entry register queue that decouples the front end from the
// recurrence engine.
// ----------------------------------------------------------------------------
`default_nettype none

module bprg_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 full,
  input  wire bprg_pkg::job_t  din,
  input  wire logic            pop,
  output logic                 empty,
  output bprg_pkg::job_t       dout
);
  import bprg_pkg::*;

  localparam int Depth = 2;
  localparam int PtrW = $clog2(Depth);

  job_t entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0] fill;
  logic do_push;
  logic do_pop;

  assign full = (fill == (PtrW+1)'(Depth));
  assign empty = (fill == '0);
  assign dout = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10: fill <= fill + (PtrW+1)'(1);
        2'b01: fill <= fill - (PtrW+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/bprg_back.sv
// ----------------------------------------------------------------------------
// Recurrence engine
// Takes one job at a time and emits its row, multiplying the running
// phasor by the channel step once per emitted channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bprg_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_empty,
  output logic                  q_pop,
  input  wire bprg_pkg::job_t   q_data,
  output logic                  empty,
  input  wire logic             pop,
  output bprg_pkg::result_t     result
);
  import bprg_pkg::*;

  logic busy;
  logic out_valid;
  cpx_t running;
  cpx_t step;
  logic [ChanW-1:0] chan;
  logic [ChanW-1:0] last_idx;
  logic load_out;
  logic is_last;
  cpx_t running_next;

  assign empty = !out_valid;
  assign q_pop = !busy && !q_empty;
  assign load_out = busy && (!out_valid || pop);
  assign is_last = (chan == last_idx);
  assign running_next = cmul(running, step);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        result <= '{shift_re: running.re, shift_im: running.im,
                    channel: chan, last: is_last};
        out_valid <= 1'b1;
        running <= running_next;
        chan <= chan + ChanW'(1);
        if (is_last) begin
          busy <= 1'b0;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        busy <= 1'b1;
        running <= q_data.start;
        step <= q_data.step;
        chan <= '0;
        last_idx <= q_data.last_idx;
      end
    end
  end

endmodule

`default_nettype wire

### src/bprg_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Watches the top-level ports for reset behaviour, result holding and row sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module bprg_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                full,
  input wire logic                empty,
  input wire logic                pop,
  input wire bprg_pkg::result_t   result
);
  import bprg_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> !full)
    else $error("input side full after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

  a_next_channel: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !result.last) |=>
      (!empty && (result.channel == $past(result.channel) + 6'd1)))
    else $error("row channels not consecutive");

  a_row_start: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && result.last) |=> (empty || (result.channel == '0)))
    else $error("new row does not start at channel zero");

endmodule

bind baseline_phasor_row_generator bprg_checker u_checker (
  .clk(clk),
  .rst(rst),
  .full(full),
  .empty(empty),
  .pop(pop),
  .result(result)
);

`default_nettype wire

### dv/baseline_phasor_row_generator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Baseline phasor row generator testbench
// Sends timeslots of start and step phasors under several channel counts and
// checks every channel result, in order, against a Q1.15 recurrence model
// kept in a scoreboard. Both the input and the result handshake idle at random.
// ----------------------------------------------------------------------------
module baseline_phasor_row_generator_tb;
  import bprg_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int TotalItems = 280;
  localparam q15_t QMax = 16'sh7fff;
  localparam q15_t QMin = 16'sh8000;

  class phasor_scoreboard;
    logic [CountW-1:0] channel_count;
    result_t expected_q[$];
    int unsigned mismatches;
    int unsigned rows;
    int unsigned channels_seen;

    function new();
      channel_count = 1;
      mismatches = 0;
      rows = 0;
      channels_seen = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    local function q15_t round_q15(longint v);
      longint r;
      r = (v + 64'sd16384) >>> 15;
      if (r > QMax) return 16'sh7fff;
      if (r < QMin) return 16'sh8000;
      return q15_t'(r);
    endfunction

    local function cpx_t times(cpx_t x, cpx_t y);
      cpx_t z;
      z.re = round_q15(longint'(x.re) * y.re - longint'(x.im) * y.im);
      z.im = round_q15(longint'(x.re) * y.im + longint'(x.im) * y.re);
      return z;
    endfunction

    local function cpx_t times_conj(cpx_t x, cpx_t y);
      cpx_t z;
      z.re = round_q15(longint'(x.re) * y.re + longint'(x.im) * y.im);
      z.im = round_q15(longint'(x.im) * y.re - longint'(x.re) * y.im);
      return z;
    endfunction

    function void note_timeslot(item_t ts);
      cpx_t a, b, da, db, phasor, step;
      result_t r;
      int n;
      n = channel_count;
      if (n < 1) n = 1;
      if (n > MAX_CHANNELS_DEFAULT) n = MAX_CHANNELS_DEFAULT;
      a.re = ts.a_start_re;
      a.im = ts.a_start_im;
      b.re = ts.b_start_re;
      b.im = ts.b_start_im;
      da.re = ts.a_step_re;
      da.im = ts.a_step_im;
      db.re = ts.b_step_re;
      db.im = ts.b_step_im;
      phasor = times_conj(b, a);
      step = (n > 1) ? times_conj(db, da) : '0;
      for (int k = 0; k < n; k++) begin
        if (k > 0) phasor = times(phasor, step);
        r.shift_re = phasor.re;
        r.shift_im = phasor.im;
        r.channel = ChanW'(k);
        r.last = (k == n - 1);
        expected_q.push_back(r);
      end
      rows++;
    endfunction

    function void check_channel(result_t got);
      result_t want;
      channels_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display({"Unexpected result, no transaction pending: ",
                    "re %0d im %0d channel %0d last %0b"},
                   got.shift_re, got.shift_im, got.channel, got.last);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got.shift_re !== want.shift_re || got.shift_im !== want.shift_im ||
          got.channel !== want.channel || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display({"Mismatch: expected re %0d im %0d channel %0d last %0b, ",
                    "got re %0d im %0d channel %0d last %0b"},
                   want.shift_re, want.shift_im, want.channel, want.last,
                   got.shift_re, got.shift_im, got.channel, got.last);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  item_t item = '0;
  logic empty;
  logic pop = 1'b0;
  result_t result;
  logic wr_en = 1'b0;
  logic [CountW-1:0] wr_data = '0;

  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned settings_used = 0;
  phasor_scoreboard sb = new();

  baseline_phasor_row_generator i_dut (
    .clk,
    .rst,
    .push,
    .full,
    .item,
    .empty,
    .pop,
    .result,
    .wr_en,
    .wr_data
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic q15_t to_q15(real x);
    int v;
    v = $rtoi(x < 0.0 ? x - 0.5 : x + 0.5);
    return q15_t'(v);
  endfunction

  function automatic q15_t extreme_value();
    q15_t v;
    case ($urandom_range(0, 5))
      0: v = 16'sh8000;
      1: v = 16'sh7fff;
      2: v = 16'sh0000;
      3: v = -16'sd1;
      4: v = 16'sd1;
      default: v = 16'sh8001;
    endcase
    return v;
  endfunction

  // Mostly phasors near the unit circle, so that long rows keep their magnitude.
  function automatic cpx_t random_phasor();
    cpx_t p;
    int mode;
    real ang;
    real amp;
    mode = $urandom_range(0, 99);
    if (mode < 60) begin
      ang = 6.283185307179586 * $urandom_range(0, 65535) / 65536.0;
      amp = 32767.0 - $urandom_range(0, 3000);
      p.re = to_q15(amp * $cos(ang));
      p.im = to_q15(amp * $sin(ang));
    end else if (mode < 85) begin
      p = $urandom;
    end else begin
      p.re = extreme_value();
      p.im = extreme_value();
    end
    return p;
  endfunction

  function automatic item_t timeslot(q15_t ar, q15_t ai, q15_t br, q15_t bi,
                                     q15_t sar, q15_t sai, q15_t sbr, q15_t sbi);
    item_t ts;
    ts.a_start_re = ar;
    ts.a_start_im = ai;
    ts.b_start_re = br;
    ts.b_start_im = bi;
    ts.a_step_re = sar;
    ts.a_step_im = sai;
    ts.b_step_re = sbr;
    ts.b_step_im = sbi;
    return ts;
  endfunction

  function automatic item_t random_timeslot();
    cpx_t a, b, da, db;
    a = random_phasor();
    b = random_phasor();
    da = random_phasor();
    db = random_phasor();
    return timeslot(a.re, a.im, b.re, b.im, da.re, da.im, db.re, db.im);
  endfunction

  function automatic logic [CountW-1:0] random_count();
    logic [CountW-1:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: c = CountW'($urandom_range(1, 8));
      6: c = CountW'($urandom_range(9, 40));
      7: begin
        case ($urandom_range(0, 2))
          0: c = CountW'(0);
          1: c = CountW'(64);
          default: c = CountW'(127);
        endcase
      end
      8: c = CountW'($urandom_range(0, 127));
      default: c = CountW'(1);
    endcase
    return c;
  endfunction

  task automatic send_timeslot(item_t ts);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= ts;
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
    sb.note_timeslot(ts);
    items_sent++;
  endtask

  task automatic drain_results();
    push <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic set_channel_count(logic [CountW-1:0] value);
    drain_results();
    repeat (4) @(posedge clk);
    wr_en <= 1'b1;
    wr_data <= value;
    @(posedge clk);
    wr_en <= 1'b0;
    sb.channel_count = value;
    settings_used++;
  endtask

  initial begin : result_sink
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty !== 1'b0) @(posedge clk);
      sb.check_channel(result);
    end
  end

  initial begin : stimulus
    logic [CountW-1:0] count;
    int effective;
    int n_items;
    bit paused_once;
    paused_once = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // One channel after reset: the step inputs must have no effect.
    send_timeslot(timeslot(0, 0, 0, 0, 0, 0, 0, 0));
    send_timeslot(timeslot(QMax, QMax, QMax, QMax, QMax, QMax, QMax, QMax));
    send_timeslot(timeslot(QMin, QMin, QMin, QMin, QMin, QMin, QMin, QMin));
    send_timeslot(timeslot(QMax, 0, 0, QMax, 1234, -5, QMin, QMax));
    send_timeslot(timeslot(QMin, QMax, QMax, QMin, QMax, QMin, QMin, QMax));

    // A count of zero behaves as a single channel.
    set_channel_count(0);
    send_timeslot(timeslot(QMin, QMin, QMax, QMin, QMax, QMax, QMin, -1));
    send_timeslot(timeslot(1, -1, -1, 1, 16384, -16384, QMin, QMin));

    set_channel_count(2);
    send_timeslot(timeslot(QMax, 0, QMax, 0, QMin, 0, QMax, 0));
    send_timeslot(timeslot(QMin, QMin, QMin, QMin, QMin, QMin, QMin, QMin));
    send_timeslot(timeslot(QMax, QMax, QMax, QMax, QMax, QMin, QMin, QMax));
    send_timeslot(timeslot(0, QMax, 16384, -16384, 0, 0, 0, 0));

    // Counts above the maximum saturate to a full row.
    set_channel_count(127);
    send_timeslot(timeslot(QMax, 0, QMax, 0, QMax, 0, 32609, 3212));
    send_timeslot(random_timeslot());
    set_channel_count(64);
    send_timeslot(timeslot(23170, 23170, QMax, 0, QMax, 0, 0, QMax));
    send_timeslot(random_timeslot());
    set_channel_count(65);
    send_timeslot(random_timeslot());

    while (items_sent < TotalItems) begin
      count = random_count();
      set_channel_count(count);
      effective = (count == 0) ? 1 : ((count > 64) ? 64 : int'(count));
      send_burst = ($urandom_range(0, 3) == 0);
      n_items = (effective > 16) ? $urandom_range(3, 8) : $urandom_range(12, 30);
      for (int i = 0; i < n_items && items_sent < TotalItems; i++) begin
        send_timeslot(random_timeslot());
        if ((!paused_once && i == 4) || $urandom_range(0, 29) == 0) begin
          drain_results();
          paused_once = 1'b1;
        end
      end
    end

    drain_results();
    repeat (16) @(posedge clk);
    $display("Covered %0d timeslots and %0d channel results",
             sb.rows, sb.channels_seen);
    $display("over %0d channel-count settings, with %0d mismatches counted.",
             settings_used, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
